FILE: hw/rtl/bse_pkg.sv
// bse_pkg: operation and status codes for the bit set stack engine
// no dependencies; used by bse_if.sv and bitset_stack_engine_core.sv

package bse_pkg;

  // operation codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_DUP    = 3'd1,
    MODE_SWAP   = 3'd2,
    MODE_UNION  = 3'd3,
    MODE_TEST   = 3'd4,
    MODE_INCL   = 3'd5,
    MODE_EXCL   = 3'd6
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // fixed field widths
  localparam int MODE_W  = 3;
  localparam int INDEX_W = 6;
  localparam int STAT_W  = 2;

endpackage

FILE: hw/rtl/bse_if.sv
// bse_in_if / bse_out_if: valid/ready channels for requests and results
// depends on bse_pkg for the fixed field widths

interface bse_in_if;
  logic                             valid;
  logic                             ready;
  logic [bse_pkg::MODE_W-1:0]       mode;
  logic [bse_pkg::INDEX_W-1:0]      bit_index;

  modport source (output valid, output mode, output bit_index, input ready);
  modport sink   (input valid, input mode, input bit_index, output ready);
endinterface

interface bse_out_if #(
  parameter int DEPTH_W = 9
);
  logic                             valid;
  logic                             ready;
  logic                             is_member;
  logic [DEPTH_W-1:0]               stack_depth;
  logic [bse_pkg::STAT_W-1:0]       status;

  modport source (output valid, output is_member, output stack_depth, output status,
                  input ready);
  modport sink   (input valid, input is_member, input stack_depth, input status,
                  output ready);
endinterface

FILE: hw/rtl/bitset_stack_engine_core.sv
// bitset_stack_engine_core: stack of bit sets, one operation per request
// depends on bse_pkg and the channel interfaces in bse_if.sv
//
// Usage
//   in_ch carries one request per handshake: mode and bit_index. out_ch returns
//   exactly one result per request: is_member, stack_depth and status, in
//   request order. The out_ch interface must be built with
//   DEPTH_W = $clog2(STACK_DEPTH + 1).
//   Output: a result is valid on out_ch in the cycle after its request is taken.
//   Throughput: one request per cycle while out_ch.ready stays high. The top
//   two sets live in registers and the rest in a single-write, single-read
//   memory whose registered read port always holds the entry under the second
//   set, so every operation completes in one pass through the update logic.
//   Stall: the result register holds while out_ch.ready is low; in_ch.ready
//   follows it, so a request is taken only when the result register is free
//   or being emptied in the same cycle.
//   Reset: synchronous rst empties the stack and drops any pending result. The
//   set memory is not cleared; only entries that have been pushed are read.
//   Errors (overflow, too few entries, index out of range) leave the stack
//   unchanged and are reported in status.

module bitset_stack_engine_core #(
  parameter int STACK_DEPTH = 256,
  parameter int SET_WIDTH   = 32
) (
  input  logic       clk,
  input  logic       rst,
  bse_in_if.sink     in_ch,
  bse_out_if.source  out_ch
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int BW = (SET_WIDTH > 1) ? $clog2(SET_WIDTH) : 1;
  localparam logic [CW-1:0] DepthMax = CW'(STACK_DEPTH);
  localparam logic [bse_pkg::INDEX_W:0] SetLimit = (bse_pkg::INDEX_W + 1)'(SET_WIDTH);

  // stack state: top two sets in registers, deeper ones in memory
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [SET_WIDTH-1:0] top_set;
  logic [SET_WIDTH-1:0] top_set_next;
  logic [SET_WIDTH-1:0] second_set;
  logic [SET_WIDTH-1:0] second_set_next;
  logic [SET_WIDTH-1:0] third_set;

  logic [SET_WIDTH-1:0] mem [STACK_DEPTH];
  logic [SET_WIDTH-1:0] mem_rd;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 wr_en;
  logic                 fwd_hit;
  logic [SET_WIDTH-1:0] fwd_data;

  // result register
  logic                 out_valid;
  logic                 out_member;
  logic [CW-1:0]        out_depth;
  bse_pkg::status_t     out_status;

  logic                 member_c;
  bse_pkg::status_t     status_c;
  logic                 accept;
  logic                 idx_ok;
  logic [BW-1:0]        bit_sel;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign idx_ok      = {1'b0, in_ch.bit_index} < SetLimit;
  assign bit_sel     = in_ch.bit_index[BW-1:0];

  // entry under the second set, with bypass of a write to the same slot
  assign third_set = fwd_hit ? fwd_data : mem_rd;

  // operation decode and next stack state
  always_comb begin
    count_next      = count;
    top_set_next    = top_set;
    second_set_next = second_set;
    member_c        = 1'b0;
    status_c        = bse_pkg::ST_OK;
    wr_en           = 1'b0;
    if (accept) begin
      unique case (in_ch.mode) inside
        bse_pkg::MODE_CLEAR: begin
          top_set_next = '0;
          count_next   = CW'(1);
        end
        bse_pkg::MODE_DUP: begin
          if (count == '0) begin
            status_c = bse_pkg::ST_UNDERFLOW;
          end else if (count >= DepthMax) begin
            status_c = bse_pkg::ST_OVERFLOW;
          end else begin
            second_set_next = top_set;
            wr_en           = (count >= CW'(2));
            count_next      = count + CW'(1);
          end
        end
        bse_pkg::MODE_SWAP: begin
          if (count < CW'(2)) begin
            status_c = bse_pkg::ST_UNDERFLOW;
          end else begin
            top_set_next    = second_set;
            second_set_next = top_set;
          end
        end
        bse_pkg::MODE_UNION: begin
          if (count < CW'(2)) begin
            status_c = bse_pkg::ST_UNDERFLOW;
          end else begin
            top_set_next    = top_set | second_set;
            second_set_next = third_set;
            count_next      = count - CW'(1);
          end
        end
        bse_pkg::MODE_TEST, bse_pkg::MODE_INCL, bse_pkg::MODE_EXCL: begin
          if (count == '0) begin
            status_c = bse_pkg::ST_UNDERFLOW;
          end else if (!idx_ok) begin
            status_c = bse_pkg::ST_RANGE;
          end else if (in_ch.mode == bse_pkg::MODE_TEST) begin
            member_c = top_set[bit_sel];
          end else if (in_ch.mode == bse_pkg::MODE_INCL) begin
            top_set_next[bit_sel] = 1'b1;
          end else begin
            top_set_next[bit_sel] = 1'b0;
          end
        end
        default: begin
          // unused mode: no change
        end
      endcase
    end
  end

  // memory addresses: push spills the old second set, read tracks the new third
  assign wr_addr = AW'(count - CW'(2));
  assign rd_addr = AW'(count_next - CW'(3));

  // stack registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    top_set    <= top_set_next;
    second_set <= second_set_next;
  end

  // set memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= second_set;
    end
    mem_rd   <= mem[rd_addr];
    fwd_data <= second_set;
  end

  // bypass flag for a read of the slot written in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (accept) begin
      out_member <= member_c;
      out_depth  <= count_next;
      out_status <= status_c;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.is_member   = out_member;
  assign out_ch.stack_depth = out_depth;
  assign out_ch.status      = out_status;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= DepthMax)
    else $error("stack count above depth");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    accept && (in_ch.mode == bse_pkg::MODE_CLEAR)
    |=> out_valid && (out_depth == CW'(1)) && (out_status == bse_pkg::ST_OK))
    else $error("clear did not leave one entry");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (rst)
    accept && (status_c != bse_pkg::ST_OK) |=> count == $past(count))
    else $error("error changed the stack depth");

  a_member_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_member |-> out_status == bse_pkg::ST_OK)
    else $error("membership reported with an error status");

  a_depth_matches: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_depth == count)
    else $error("reported depth differs from stack count");

endmodule
